FILE: hw/rtl/rbd_pkg.sv
// Shared types and constants for the ring buffer deque.
// Request/response payload structs, cell link type and cell operation codes.
// No dependencies.
package rbd_pkg;

	localparam int MAX_ENTRIES = 16;
	localparam int WORD_BITS   = 32;
	localparam int CAP_BITS    = 5;
	localparam int CNT_BITS    = $clog2(MAX_ENTRIES + 1);
	localparam int EXT_BITS    = (CAP_BITS > CNT_BITS) ? CAP_BITS : CNT_BITS;

	localparam logic [CAP_BITS-1:0] CAP_RESET = CAP_BITS'(16);

	// request kinds
	localparam logic [2:0] KIND_PUSH_FRONT = 3'd0;
	localparam logic [2:0] KIND_PUSH_BACK  = 3'd1;
	localparam logic [2:0] KIND_POP_FRONT  = 3'd2;
	localparam logic [2:0] KIND_POP_BACK   = 3'd3;
	localparam logic [2:0] KIND_LOOK       = 3'd4;

	typedef logic [WORD_BITS-1:0] word_t;

	typedef struct packed {
		logic [2:0]                  kind;
		logic signed [WORD_BITS-1:0] value;
	} in_item_t;

	typedef struct packed {
		logic                        accepted;
		logic signed [WORD_BITS-1:0] front_word;
		logic signed [WORD_BITS-1:0] rear_word;
		logic                        is_empty;
		logic                        is_full;
	} out_item_t;

	// what one cell hands its neighbor
	typedef struct packed {
		logic  valid;
		word_t data;
	} link_t;

	// row-wide operation, same for every cell
	typedef enum logic [2:0] {
		OP_HOLD,
		OP_SHIFT_IN_FRONT,
		OP_SHIFT_OUT_FRONT,
		OP_APPEND,
		OP_DROP_LAST
	} cell_op_t;

	// what the row reports back to the control
	typedef struct packed {
		word_t                  front_word;
		word_t                  rear_word;
		logic [MAX_ENTRIES-1:0] valid_vec;
	} row_status_t;

endpackage

FILE: hw/rtl/ring_buffer_deque.sv
// Ring buffer deque top level: request decode, entry count, capacity, response register.
// Depends on rbd_pkg and rbd_row.
//
//   channel  direction  handshake            payload
//   in       in         in_valid/in_ready    in_item_t  (kind, value)
//   out      out        out_valid/out_ready  out_item_t (accepted, words, flags)
//   cfg      in         cfg_valid/cfg_ready  capacity_in_use, 5 bits
//
// For each request the cell row updates at accept, and the response is read
// from the row into the output register once that register is free or being taken.
// A new request is not accepted until that row read has been done.
// Reset clears cell valid bits and entry count and sets capacity to 16; no clearing pass.
// A stalled response holds the output register; a new request may still enter
// while it waits, and its own response waits behind it. cfg is always ready.
module ring_buffer_deque
	import rbd_pkg::*;
(
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	output logic                in_ready,
	input  in_item_t            in_data,
	output logic                out_valid,
	input  logic                out_ready,
	output out_item_t           out_data,
	input  logic                cfg_valid,
	output logic                cfg_ready,
	input  logic [CAP_BITS-1:0] cfg_data
);

	logic [CAP_BITS-1:0] cap_q;
	logic [CNT_BITS-1:0] count_q;
	logic                pend_s1;
	logic                ok_s1;
	logic                out_valid_q;
	out_item_t           out_q;

	logic [EXT_BITS-1:0] cap_ext;
	logic [EXT_BITS-1:0] cap_eff;
	logic [EXT_BITS-1:0] cnt_ext;
	logic                full;
	logic                empty;
	logic                ok;
	cell_op_t            req_op;
	cell_op_t            row_op;
	logic                in_fire;
	logic                load;
	row_status_t         row_st;

	// capacity: zero acts as one, above the row depth saturates
	assign cap_ext = EXT_BITS'(cap_q);
	assign cap_eff = (cap_q == '0) ? EXT_BITS'(1) :
		(cap_ext > EXT_BITS'(MAX_ENTRIES)) ? EXT_BITS'(MAX_ENTRIES) : cap_ext;
	assign cnt_ext = EXT_BITS'(count_q);
	// a lowered capacity below the count still reads as full
	assign full    = cnt_ext >= cap_eff;
	assign empty   = (count_q == '0);

	// request decode into a row operation
	always_comb begin
		req_op = OP_HOLD;
		ok     = 1'b0;
		case (in_data.kind)
			KIND_PUSH_FRONT: begin
				if (!full) begin
					req_op = OP_SHIFT_IN_FRONT;
					ok     = 1'b1;
				end
			end
			KIND_PUSH_BACK: begin
				if (!full) begin
					req_op = OP_APPEND;
					ok     = 1'b1;
				end
			end
			KIND_POP_FRONT: begin
				if (!empty) begin
					req_op = OP_SHIFT_OUT_FRONT;
					ok     = 1'b1;
				end
			end
			KIND_POP_BACK: begin
				if (!empty) begin
					req_op = OP_DROP_LAST;
					ok     = 1'b1;
				end
			end
			KIND_LOOK: ok = 1'b1;
			default:   ok = 1'b0; // unknown kind: no change, refused
		endcase
	end

	assign in_ready = ~pend_s1;
	assign in_fire  = in_valid & in_ready;
	assign row_op   = in_fire ? req_op : OP_HOLD;
	// response moves into the output register when it is free or being taken
	assign load     = pend_s1 & (~out_valid_q | out_ready);

	rbd_row u_row (
		.clk       (clk),
		.arst_n    (arst_n),
		.op        (row_op),
		.push_word (word_t'(in_data.value)),
		.status    (row_st)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cap_q       <= CAP_RESET;
			count_q     <= '0;
			pend_s1     <= 1'b0;
			ok_s1       <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (cfg_valid) begin
				cap_q <= cfg_data;
			end
			if (in_fire) begin
				pend_s1 <= 1'b1;
				ok_s1   <= ok;
				case (req_op)
					OP_SHIFT_IN_FRONT, OP_APPEND:   count_q <= count_q + CNT_BITS'(1);
					OP_SHIFT_OUT_FRONT, OP_DROP_LAST: count_q <= count_q - CNT_BITS'(1);
					default:                        count_q <= count_q;
				endcase
			end else if (load) begin
				pend_s1 <= 1'b0;
			end
			if (load) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			out_q.accepted   <= ok_s1;
			out_q.front_word <= row_st.front_word;
			out_q.rear_word  <= row_st.rear_word;
			out_q.is_empty   <= ~row_st.valid_vec[0];
			out_q.is_full    <= full;
		end
	end

	assign cfg_ready = 1'b1;
	assign out_valid = out_valid_q;
	assign out_data  = out_q;

`ifndef SYNTHESIS
	// count never passes the row depth
	assert property (@(posedge clk) disable iff (!arst_n)
		CNT_BITS'(count_q) <= CNT_BITS'(MAX_ENTRIES))
		else $error("deque count above depth");

	// cell valid bits agree with the entry count
	assert property (@(posedge clk) disable iff (!arst_n)
		$countones(row_st.valid_vec) == 32'(count_q))
		else $error("cell valid bits disagree with count");

	// an accepted push grows the deque by one
	assert property (@(posedge clk) disable iff (!arst_n)
		in_fire && ok && (in_data.kind == KIND_PUSH_FRONT || in_data.kind == KIND_PUSH_BACK)
		|=> count_q == $past(count_q) + CNT_BITS'(1))
		else $error("push did not grow count");

	// an empty response carries zero words
	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && out_q.is_empty |-> out_q.front_word == '0 && out_q.rear_word == '0)
		else $error("empty response with nonzero words");
`endif

endmodule

FILE: hw/rtl/rbd_cell.sv
// One deque cell: a word and its valid bit.
// Takes from its left or right neighbor as the row operation says.
// Depends on rbd_pkg.
module rbd_cell
	import rbd_pkg::*;
(
	input  logic     clk,
	input  logic     arst_n,
	input  cell_op_t op,
	input  word_t    push_word,
	input  link_t    left,
	input  link_t    right,
	output link_t    cur,
	output logic     tail
);

	logic  valid_q;
	word_t data_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else begin
			case (op)
				OP_SHIFT_IN_FRONT:  valid_q <= left.valid;
				OP_SHIFT_OUT_FRONT: valid_q <= right.valid;
				OP_APPEND:          valid_q <= valid_q | left.valid;
				OP_DROP_LAST:       valid_q <= valid_q & right.valid;
				default:            valid_q <= valid_q;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		case (op)
			OP_SHIFT_IN_FRONT:  data_q <= left.data;
			OP_SHIFT_OUT_FRONT: data_q <= right.data;
			OP_APPEND: begin
				// first empty cell behind a full one takes the word
				if (!valid_q && left.valid) begin
					data_q <= push_word;
				end
			end
			default: data_q <= data_q;
		endcase
	end

	assign cur.valid = valid_q;
	assign cur.data  = data_q;
	assign tail      = valid_q & ~right.valid;

endmodule

FILE: hw/rtl/rbd_row.sv
// Row of MAX_ENTRIES deque cells, front at cell 0.
// Wires neighbor links and picks the front and rear words.
// Depends on rbd_pkg and rbd_cell.
module rbd_row
	import rbd_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  cell_op_t    op,
	input  word_t       push_word,
	output row_status_t status
);

	link_t                  cur  [MAX_ENTRIES];
	link_t                  lft  [MAX_ENTRIES];
	link_t                  rgt  [MAX_ENTRIES];
	logic [MAX_ENTRIES-1:0] tail;
	word_t                  rear;

	for (genvar i = 0; i < MAX_ENTRIES; i++) begin : g_cell
		if (i == 0) begin : g_first
			// push word enters at the front as an always-valid neighbor
			assign lft[i] = '{valid: 1'b1, data: push_word};
		end else begin : g_mid
			assign lft[i] = cur[i-1];
		end
		if (i == MAX_ENTRIES - 1) begin : g_last
			assign rgt[i] = '{valid: 1'b0, data: '0};
		end else begin : g_nxt
			assign rgt[i] = cur[i+1];
		end

		rbd_cell u_cell (
			.clk       (clk),
			.arst_n    (arst_n),
			.op        (op),
			.push_word (push_word),
			.left      (lft[i]),
			.right     (rgt[i]),
			.cur       (cur[i]),
			.tail      (tail[i])
		);

		assign status.valid_vec[i] = cur[i].valid;
	end

	// at most one tail flag is set; and-or select gives zero when empty
	always_comb begin
		rear = '0;
		for (int i = 0; i < MAX_ENTRIES; i++) begin
			rear = rear | (cur[i].data & {WORD_BITS{tail[i]}});
		end
	end

	assign status.front_word = cur[0].valid ? cur[0].data : '0;
	assign status.rear_word  = rear;

endmodule
